FILE: hdl/quaternion_orientation_update_macros.svh
// Assertion macros for the quaternion orientation update block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef QUATERNION_ORIENTATION_UPDATE_MACROS_SVH
`define QUATERNION_ORIENTATION_UPDATE_MACROS_SVH

// Check a property on every edge outside reset.
`define QOU_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("port check failed");

// Check a property on every edge, reset included.
`define QOU_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("reset check failed");

`endif

FILE: hdl/qou_pkg.sv
// Package for the quaternion orientation update block: codes, widths,
// sequencer states and the Hamilton product term tables. No dependencies.
package qou_pkg;

  localparam logic [1:0] REQ_INTEGRATE = 2'd0;
  localparam logic [1:0] REQ_ROTATE    = 2'd1;
  localparam logic [1:0] REQ_LOAD      = 2'd2;
  localparam logic [1:0] REQ_UNUSED    = 2'd3;

  localparam logic [1:0] STAT_UPDATED = 2'd0;
  localparam logic [1:0] STAT_SKIPPED = 2'd1;
  localparam logic [1:0] STAT_FAULT   = 2'd2;

  // Width of the unnormalized components and their magnitudes.
  localparam int C_W = 52;
  localparam logic signed [31:0] ONE_Q29 = 32'sh2000_0000;
  localparam logic [C_W-1:0] NORM_HI = C_W'(1) << 30;
  localparam logic [C_W-1:0] NORM_LO = C_W'(1) << 29;

  // Quotient width of the normalizing division.
  localparam int QUOT_W = 30;

  localparam logic [2:0] TERM_LAST  = 3'd2;
  localparam logic [2:0] TERM_DT_LO = 3'd3;
  localparam logic [2:0] TERM_DT_HI = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MACC, S_NORM, S_SHIFT, S_SQ_MUL, S_SQ_ACC,
    S_SQRT_GO, S_SQRT, S_DIV_GO, S_DIV, S_OUT
  } qou_state_t;

  // Vector component (0 x, 1 y, 2 z) of product term t of component c.
  function automatic logic [1:0] term_vec(logic [1:0] c, logic [1:0] t);
    logic [1:0] v;
    unique case (c)
      2'd0, 2'd1: v = t;
      2'd2:       v = (t == 2'd0) ? 2'd1 : (t == 2'd1) ? 2'd2 : 2'd0;
      default:    v = (t == 2'd0) ? 2'd2 : (t == 2'd1) ? 2'd0 : 2'd1;
    endcase
    return v;
  endfunction

  // State component (0 w, 1 i, 2 j, 3 k) of product term t of component c.
  function automatic logic [1:0] term_q(logic [1:0] c, logic [1:0] t);
    logic [1:0] v;
    unique case (c)
      2'd0:    v = (t == 2'd0) ? 2'd1 : (t == 2'd1) ? 2'd2 : 2'd3;
      2'd1:    v = (t == 2'd0) ? 2'd0 : (t == 2'd1) ? 2'd3 : 2'd2;
      2'd2:    v = (t == 2'd0) ? 2'd0 : (t == 2'd1) ? 2'd1 : 2'd3;
      default: v = (t == 2'd0) ? 2'd0 : (t == 2'd1) ? 2'd2 : 2'd1;
    endcase
    return v;
  endfunction

  // Sign of the term for the left product (0,v)*q.
  function automatic logic term_neg(logic [1:0] c, logic [1:0] t);
    return (c == 2'd0) || (t == 2'd2);
  endfunction

endpackage

FILE: hdl/qou_mul.sv
// Shared signed 33x33 multiplier with a registered product.
// Standalone; used by the quaternion orientation update sequencer.
module qou_mul (
  input  logic               clk,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a_i * b_i;
  end

  assign p_o = p_r;

endmodule

FILE: hdl/qou_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Standalone; used by the quaternion orientation update sequencer.
module qou_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_i,
  input  logic [63:0] v_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] trial;
  logic        fits;

  assign trial = res_r + bit_r;
  assign fits  = v_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      v_r   <= v_i;
      res_r <= '0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r) begin
      if (fits) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done_o = done_r;
  assign root_o = res_r[31:0];

endmodule

FILE: hdl/qou_div.sv
// Restoring divider for (num << 29) / den, one quotient bit per cycle.
// Depends on qou_pkg for the quotient width.
module qou_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic [qou_pkg::QUOT_W-1:0] num_i,
  input  logic [31:0]                den_i,
  output logic                       done_o,
  output logic [qou_pkg::QUOT_W-1:0] quot_o
);

  localparam logic [4:0] LAST_BIT = 5'(qou_pkg::QUOT_W - 1);

  logic                       busy_r;
  logic                       done_r;
  logic [4:0]                 cnt_r;
  logic [31:0]                rem_r;
  logic [31:0]                den_r;
  logic                       lsb_r;
  logic [qou_pkg::QUOT_W-1:0] quot_r;
  logic [32:0]                trial;
  logic [32:0]                diff;
  logic                       fits;

  // Only the numerator's lowest bit remains to shift in; the rest is zeros.
  assign trial = {rem_r, (cnt_r == LAST_BIT) ? lsb_r : 1'b0};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= LAST_BIT;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= 32'(num_i >> 1);
      lsb_r <= num_i[0];
      den_r <= den_i;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[31:0] : trial[31:0];
      quot_r <= {quot_r[qou_pkg::QUOT_W-2:0], fits};
    end
  end

  assign done_o = done_r;
  assign quot_o = quot_r;

endmodule

FILE: hdl/quaternion_orientation_update.sv
// Top level of the quaternion orientation update block.
// Depends on qou_pkg, qou_mul, qou_sqrt and qou_div.
//
// Keeps one orientation quaternion (Q2.29, reset to identity) and serves one
// request at a time. A request is taken only while the sequencer is idle;
// in_tready drops for the whole update. Load and skipped requests (zero
// vector or unused type) go straight to the output state, which they leave
// once the result register is free; only then is the next request taken.
// Rotate runs the Hamilton product terms, three per component, on the one
// shared 33x33 multiplier, each term in a multiply and an accumulate state;
// integrate adds two more products per component for the dt scaling.
// Normalization then takes the largest magnitude, shifts all four one bit
// per step (up to 29 bits), sums the squares on the same multiplier, runs
// the bit-serial square root and then the restoring divider once per
// component, and ends in the output state. A zero magnitude at normalization
// keeps the state and reports a fault. The result register lets the next
// request in while a result waits.
module quaternion_orientation_update (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vec_x, vec_y, vec_z, dt, load_w, load_i, load_j, load_k
  input  logic [239:0] in_tdata,
  // req_type
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // q_w, q_i, q_j, q_k
  output logic [127:0] out_tdata,
  // status
  output logic [1:0]   out_tuser
);

  localparam int CW = qou_pkg::C_W;

  qou_pkg::qou_state_t state_r, state_nxt;

  logic signed [31:0]   q_r [4];
  logic signed [31:0]   q_nxt [4];
  logic signed [31:0]   vec_r [3];
  logic signed [31:0]   vec_nxt [3];
  logic [15:0]          dt_r, dt_nxt;
  logic                 integ_r, integ_nxt;
  logic [1:0]           comp_r, comp_nxt;
  logic [2:0]           term_r, term_nxt;
  logic signed [CW-1:0] acc_r, acc_nxt;
  logic signed [63:0]   dacc_r, dacc_nxt;
  logic [CW-1:0]        c_r [4];
  logic [CW-1:0]        c_nxt [4];
  logic [CW-1:0]        m_r [4];
  logic [CW-1:0]        m_nxt [4];
  logic [3:0]           neg_r, neg_nxt;
  logic [CW-1:0]        mx_r, mx_nxt;
  logic [61:0]          sum_r, sum_nxt;
  logic [31:0]          r_r, r_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [127:0]         out_data_r, out_data_nxt;
  logic [1:0]           out_user_r, out_user_nxt;

  logic signed [32:0]   mul_a, mul_b;
  logic signed [65:0]   mul_p;
  logic signed [65:0]   prod_sh;
  logic [CW-1:0]        term_val;
  logic [CW-1:0]        acc_add;
  logic                 tneg;
  logic signed [CW-1:0] h;
  logic signed [31:0]   vsel, qsel;
  logic [1:0]           qidx;
  logic signed [63:0]   dsum, dval;
  logic [CW-1:0]        c_int;
  logic                 vec_zero;
  logic                 sqrt_go, sqrt_done;
  logic [31:0]          sqrt_root;
  logic                 div_go, div_done;
  logic [qou_pkg::QUOT_W-1:0] div_quot;
  logic [31:0]          quot_ext;

  function automatic logic [CW-1:0] max4(logic [CW-1:0] a, logic [CW-1:0] b,
                                         logic [CW-1:0] c, logic [CW-1:0] d);
    logic [CW-1:0] ab, cd;
    ab = (a > b) ? a : b;
    cd = (c > d) ? c : d;
    return (ab > cd) ? ab : cd;
  endfunction

  assign in_tready  = (state_r == qou_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign vec_zero   = (in_tdata[95:0] == '0);

  qou_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  qou_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (sqrt_go),
    .v_i     ({2'b00, sum_r}),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  qou_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_go),
    .num_i   (m_r[comp_r][qou_pkg::QUOT_W-1:0]),
    .den_i   (r_r),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Operand select for the shared multiplier.
  always_comb begin
    qidx = (term_r >= qou_pkg::TERM_DT_LO) ? comp_r
                                            : qou_pkg::term_q(comp_r, term_r[1:0]);
    vsel = vec_r[qou_pkg::term_vec(comp_r, term_r[1:0])];
    qsel = q_r[qidx];
    h    = acc_r >>> 1;
    if (state_r == qou_pkg::S_SQ_MUL) begin
      mul_a = {3'b000, m_r[comp_r][29:0]};
      mul_b = {3'b000, m_r[comp_r][29:0]};
    end else begin
      unique case (term_r)
        qou_pkg::TERM_DT_LO: begin
          mul_a = {9'd0, h[23:0]};
          mul_b = {17'd0, dt_r};
        end
        qou_pkg::TERM_DT_HI: begin
          mul_a = {{5{h[CW-1]}}, h[CW-1:24]};
          mul_b = {17'd0, dt_r};
        end
        default: begin
          mul_a = {vsel[31], vsel};
          mul_b = {qsel[31], qsel};
        end
      endcase
    end
  end

  // Term accumulation and the dt scaling of integrate.
  always_comb begin
    prod_sh  = mul_p >>> 16;
    term_val = prod_sh[CW-1:0];
    // Right product flips the sign of every cross term.
    tneg     = qou_pkg::term_neg(comp_r, term_r[1:0]) ^
               (!integ_r && (comp_r != 2'd0) && (term_r != 3'd0));
    acc_add  = tneg ? (acc_r - term_val) : (acc_r + term_val);
    dsum     = dacc_r + {mul_p[39:0], 24'd0};
    dval     = dsum >>> 16;
    c_int    = {{(CW-32){qsel[31]}}, qsel} + dval[CW-1:0];
    quot_ext = {{(32-qou_pkg::QUOT_W){1'b0}}, div_quot};
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    vec_nxt       = vec_r;
    dt_nxt        = dt_r;
    integ_nxt     = integ_r;
    comp_nxt      = comp_r;
    term_nxt      = term_r;
    acc_nxt       = acc_r;
    dacc_nxt      = dacc_r;
    c_nxt         = c_r;
    m_nxt         = m_r;
    neg_nxt       = neg_r;
    mx_nxt        = mx_r;
    sum_nxt       = sum_r;
    r_nxt         = r_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    sqrt_go       = 1'b0;
    div_go        = 1'b0;

    // Drop the result once taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      qou_pkg::S_IDLE: begin
        if (in_tvalid) begin
          vec_nxt[0] = $signed(in_tdata[31:0]);
          vec_nxt[1] = $signed(in_tdata[63:32]);
          vec_nxt[2] = $signed(in_tdata[95:64]);
          dt_nxt     = in_tdata[111:96];
          integ_nxt  = (in_tuser == qou_pkg::REQ_INTEGRATE);
          comp_nxt   = 2'd0;
          term_nxt   = 3'd0;
          acc_nxt    = '0;
          priority if (in_tuser == qou_pkg::REQ_LOAD) begin
            q_nxt[0]   = $signed(in_tdata[143:112]);
            q_nxt[1]   = $signed(in_tdata[175:144]);
            q_nxt[2]   = $signed(in_tdata[207:176]);
            q_nxt[3]   = $signed(in_tdata[239:208]);
            status_nxt = qou_pkg::STAT_UPDATED;
            state_nxt  = qou_pkg::S_OUT;
          end else if ((in_tuser != qou_pkg::REQ_INTEGRATE &&
                        in_tuser != qou_pkg::REQ_ROTATE) || vec_zero) begin
            status_nxt = qou_pkg::STAT_SKIPPED;
            state_nxt  = qou_pkg::S_OUT;
          end else begin
            state_nxt = qou_pkg::S_MUL;
          end
        end
      end

      qou_pkg::S_MUL: begin
        state_nxt = qou_pkg::S_MACC;
      end

      qou_pkg::S_MACC: begin
        state_nxt = qou_pkg::S_MUL;
        priority if (term_r == qou_pkg::TERM_DT_LO) begin
          dacc_nxt = mul_p[63:0];
          term_nxt = qou_pkg::TERM_DT_HI;
        end else if (term_r == qou_pkg::TERM_DT_HI) begin
          c_nxt[comp_r] = c_int;
        end else if (term_r != qou_pkg::TERM_LAST) begin
          acc_nxt  = acc_add;
          term_nxt = term_r + 3'd1;
        end else if (integ_r) begin
          acc_nxt  = acc_add;
          term_nxt = qou_pkg::TERM_DT_LO;
        end else begin
          c_nxt[comp_r] = acc_add;
        end
        // Component done: advance to the next one or to normalization.
        if (term_r == qou_pkg::TERM_DT_HI ||
            (term_r == qou_pkg::TERM_LAST && !integ_r)) begin
          acc_nxt  = '0;
          term_nxt = 3'd0;
          if (comp_r == 2'd3) begin
            state_nxt = qou_pkg::S_NORM;
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end
      end

      qou_pkg::S_NORM: begin
        for (int n = 0; n < 4; n++) begin
          neg_nxt[n] = c_r[n][CW-1];
          m_nxt[n]   = c_r[n][CW-1] ? (~c_r[n] + 1'b1) : c_r[n];
        end
        mx_nxt    = max4(m_nxt[0], m_nxt[1], m_nxt[2], m_nxt[3]);
        state_nxt = qou_pkg::S_SHIFT;
      end

      qou_pkg::S_SHIFT: begin
        priority if (mx_r == '0) begin
          status_nxt = qou_pkg::STAT_FAULT;
          state_nxt  = qou_pkg::S_OUT;
        end else if (mx_r >= qou_pkg::NORM_HI) begin
          for (int n = 0; n < 4; n++) m_nxt[n] = m_r[n] >> 1;
          mx_nxt = mx_r >> 1;
        end else if (mx_r < qou_pkg::NORM_LO) begin
          for (int n = 0; n < 4; n++) m_nxt[n] = m_r[n] << 1;
          mx_nxt = mx_r << 1;
        end else begin
          comp_nxt  = 2'd0;
          sum_nxt   = '0;
          state_nxt = qou_pkg::S_SQ_MUL;
        end
      end

      qou_pkg::S_SQ_MUL: begin
        state_nxt = qou_pkg::S_SQ_ACC;
      end

      qou_pkg::S_SQ_ACC: begin
        sum_nxt = sum_r + mul_p[61:0];
        if (comp_r == 2'd3) begin
          state_nxt = qou_pkg::S_SQRT_GO;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = qou_pkg::S_SQ_MUL;
        end
      end

      qou_pkg::S_SQRT_GO: begin
        sqrt_go   = 1'b1;
        state_nxt = qou_pkg::S_SQRT;
      end

      qou_pkg::S_SQRT: begin
        if (sqrt_done) begin
          r_nxt     = sqrt_root;
          comp_nxt  = 2'd0;
          state_nxt = qou_pkg::S_DIV_GO;
        end
      end

      qou_pkg::S_DIV_GO: begin
        div_go    = 1'b1;
        state_nxt = qou_pkg::S_DIV;
      end

      qou_pkg::S_DIV: begin
        if (div_done) begin
          q_nxt[comp_r] = neg_r[comp_r] ? $signed(~quot_ext + 32'd1) : $signed(quot_ext);
          if (comp_r == 2'd3) begin
            status_nxt = qou_pkg::STAT_UPDATED;
            state_nxt  = qou_pkg::S_OUT;
          end else begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = qou_pkg::S_DIV_GO;
          end
        end
      end

      qou_pkg::S_OUT: begin
        // Hold until the result register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {q_r[3], q_r[2], q_r[1], q_r[0]};
          out_user_nxt  = status_r;
          state_nxt     = qou_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = qou_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qou_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      q_r[0]      <= qou_pkg::ONE_Q29;
      q_r[1]      <= '0;
      q_r[2]      <= '0;
      q_r[3]      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      q_r         <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vec_r      <= vec_nxt;
    dt_r       <= dt_nxt;
    integ_r    <= integ_nxt;
    comp_r     <= comp_nxt;
    term_r     <= term_nxt;
    acc_r      <= acc_nxt;
    dacc_r     <= dacc_nxt;
    c_r        <= c_nxt;
    m_r        <= m_nxt;
    neg_r      <= neg_nxt;
    mx_r       <= mx_nxt;
    sum_r      <= sum_nxt;
    r_r        <= r_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

FILE: hdl/qou_checker.sv
// Port checker for the quaternion orientation update block, bound to the top.
// Depends on quaternion_orientation_update_macros.svh.
`include "quaternion_orientation_update_macros.svh"

module qou_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready
);

  // A stalled result stays offered.
  `QOU_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid)
  // An accepted request occupies the block in the following cycle.
  `QOU_ASSERT(a_busy_after_req, in_tvalid && in_tready |=> !in_tready)
  // Reset empties the result register.
  `QOU_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid)

endmodule

bind quaternion_orientation_update qou_checker u_qou_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

FILE: dv/quaternion_orientation_update_tb.sv
// Testbench for the quaternion orientation update block: directed requests from a table,
// then random requests, all checked against a bit-accurate predictor. Depends on qou_pkg.
module quaternion_orientation_update_tb;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [31:0] vx, vy, vz;
    logic [15:0] dt;
    logic signed [31:0] lw, li, lj, lk;
  } request_t;

  typedef struct packed {
    logic signed [31:0] w, i, j, k;
    logic [1:0] status;
  } attitude_t;

  // Directed row: request plus an optional typed-in expectation.
  typedef struct packed {
    request_t req;
    logic has_exp;
    attitude_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [239:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [1:0] out_tuser;

  always #10 clk = ~clk;

  quaternion_orientation_update dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // Predictor state: the orientation after every accepted request.
  logic signed [31:0] att_q [4];
  attitude_t pending_att [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit long_hold = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  longint cycles = 0;

  function automatic logic signed [63:0] floor_shr(logic signed [63:0] x, int s);
    return x >>> s;
  endfunction

  function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
    return floor_shr(a * b, 16);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // Normalize into att_q; return 0 on zero magnitude, state untouched.
  function automatic bit renormalize(logic signed [63:0] c [4]);
    logic [63:0] m [4];
    logic [63:0] mx, sum, r, mag;
    bit neg [4];
    mx = 0;
    sum = 0;
    for (int n = 0; n < 4; n++) begin
      neg[n] = c[n] < 0;
      m[n] = neg[n] ? -c[n] : c[n];
      if (m[n] > mx) mx = m[n];
    end
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      for (int n = 0; n < 4; n++) m[n] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int n = 0; n < 4; n++) m[n] <<= 1;
      mx <<= 1;
    end
    for (int n = 0; n < 4; n++) sum += m[n] * m[n];
    r = root_floor(sum);
    for (int n = 0; n < 4; n++) begin
      mag = (m[n] << 29) / r;
      att_q[n] = neg[n] ? -mag[31:0] : mag[31:0];
    end
    return 1;
  endfunction

  function automatic attitude_t update_attitude(request_t rq);
    logic signed [63:0] x, y, z, qw, qi, qj, qk;
    logic signed [63:0] p [4];
    logic signed [63:0] c [4];
    attitude_t a;
    logic [1:0] st;
    x = rq.vx; y = rq.vy; z = rq.vz;
    qw = att_q[0]; qi = att_q[1]; qj = att_q[2]; qk = att_q[3];
    st = qou_pkg::STAT_UPDATED;
    if (rq.kind == qou_pkg::REQ_LOAD) begin
      att_q[0] = rq.lw; att_q[1] = rq.li; att_q[2] = rq.lj; att_q[3] = rq.lk;
    end else if (!(rq.kind inside {qou_pkg::REQ_INTEGRATE, qou_pkg::REQ_ROTATE}) ||
                 (x == 0 && y == 0 && z == 0)) begin
      st = qou_pkg::STAT_SKIPPED;
    end else if (rq.kind == qou_pkg::REQ_INTEGRATE) begin
      p[0] = -qmul(x, qi) - qmul(y, qj) - qmul(z, qk);
      p[1] = qmul(x, qw) + qmul(y, qk) - qmul(z, qj);
      p[2] = qmul(y, qw) + qmul(z, qi) - qmul(x, qk);
      p[3] = qmul(z, qw) + qmul(x, qj) - qmul(y, qi);
      c[0] = qw; c[1] = qi; c[2] = qj; c[3] = qk;
      for (int n = 0; n < 4; n++)
        c[n] += floor_shr(floor_shr(p[n], 1) * $signed({48'd0, rq.dt}), 16);
      if (!renormalize(c)) st = qou_pkg::STAT_FAULT;
    end else begin
      c[0] = -qmul(qi, x) - qmul(qj, y) - qmul(qk, z);
      c[1] = qmul(qw, x) + qmul(qj, z) - qmul(qk, y);
      c[2] = qmul(qw, y) + qmul(qk, x) - qmul(qi, z);
      c[3] = qmul(qw, z) + qmul(qi, y) - qmul(qj, x);
      if (!renormalize(c)) st = qou_pkg::STAT_FAULT;
    end
    a.w = att_q[0]; a.i = att_q[1]; a.j = att_q[2]; a.k = att_q[3];
    a.status = st;
    return a;
  endfunction

  function automatic logic [31:0] rand_word();
    unique case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 262143)) - 131072);
      default: return $urandom();
    endcase
  endfunction

  // Random request: mostly integrate/rotate, with extreme, small or full-range vector words.
  function automatic request_t random_request();
    request_t rq;
    int pick;
    pick = $urandom_range(0, 99);
    rq.kind = pick < 40 ? qou_pkg::REQ_INTEGRATE : pick < 80 ? qou_pkg::REQ_ROTATE :
              pick < 95 ? qou_pkg::REQ_LOAD : qou_pkg::REQ_UNUSED;
    rq.vx = rand_word(); rq.vy = rand_word(); rq.vz = rand_word();
    if ($urandom_range(0, 19) == 0) begin
      rq.vx = 0; rq.vy = 0; rq.vz = 0;
    end
    rq.dt = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1) * 16'hffff)
                                        : 16'($urandom());
    rq.lw = rand_word(); rq.li = rand_word(); rq.lj = rand_word(); rq.lk = rand_word();
    // Load an all-zero state now and then so zero-magnitude faults stay reachable.
    if ($urandom_range(0, 9) == 0) begin
      rq.lw = 0; rq.li = 0; rq.lj = 0; rq.lk = 0;
    end
    return rq;
  endfunction

  function automatic request_t make_req(logic [1:0] kind, logic [31:0] vx, logic [31:0] vy,
                                        logic [31:0] vz, logic [15:0] dt, logic [31:0] lw,
                                        logic [31:0] li, logic [31:0] lj, logic [31:0] lk);
    request_t rq;
    rq.kind = kind; rq.vx = vx; rq.vy = vy; rq.vz = vz; rq.dt = dt;
    rq.lw = lw; rq.li = li; rq.lj = lj; rq.lk = lk;
    return rq;
  endfunction

  // Offer one request and hold it until the block takes it; predict on acceptance.
  // Valid stays high after acceptance until the next request or an idle gap.
  task automatic send_request(request_t rq);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= rq.kind;
    in_tdata <= {rq.lk, rq.lj, rq.li, rq.lw, rq.dt, rq.vz, rq.vy, rq.vx};
    do @(posedge clk); while (!in_tready);
    pending_att.push_back(update_attitude(rq));
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_att.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (long_hold && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 2000;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    attitude_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tdata[127:96],
             out_tuser};
      if (pending_att.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_att.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  localparam logic [31:0] ONE = 32'h2000_0000;
  localparam logic [31:0] MINW = 32'h8000_0000;
  localparam logic [31:0] MAXW = 32'h7fff_ffff;

  row_t plan [$];

  initial begin
    // Reset, skip, load and extremes; typed expectations where obvious.
    plan.push_back('{make_req(qou_pkg::REQ_ROTATE, 0, 0, 0, 16'h1234, 0, 0, 0, 0), 1'b1,
                     '{ONE, 0, 0, 0, qou_pkg::STAT_SKIPPED}});
    plan.push_back('{make_req(qou_pkg::REQ_UNUSED, 32'h10000, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     '{ONE, 0, 0, 0, qou_pkg::STAT_SKIPPED}});
    plan.push_back('{make_req(qou_pkg::REQ_ROTATE, 32'h10000, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     '{0, ONE, 0, 0, qou_pkg::STAT_UPDATED}});
    plan.push_back('{make_req(qou_pkg::REQ_LOAD, 0, 0, 0, 0, MINW, MAXW, MINW, MAXW), 1'b1,
                     '{MINW, MAXW, MINW, MAXW, qou_pkg::STAT_UPDATED}});
    plan.push_back('{make_req(qou_pkg::REQ_INTEGRATE, MAXW, MINW, MAXW, 16'hffff,
                              0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{make_req(qou_pkg::REQ_ROTATE, MINW, MINW, MINW, 0, 0, 0, 0, 0),
                     1'b0, '0});
    plan.push_back('{make_req(qou_pkg::REQ_LOAD, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     '{0, 0, 0, 0, qou_pkg::STAT_UPDATED}});
    // All-zero state: integrate with zero dt faults, rotate faults too.
    plan.push_back('{make_req(qou_pkg::REQ_INTEGRATE, 32'h10000, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     '{0, 0, 0, 0, qou_pkg::STAT_FAULT}});
    plan.push_back('{make_req(qou_pkg::REQ_ROTATE, 32'h10000, 32'h1, MAXW, 0, 0, 0, 0, 0),
                     1'b1, '{0, 0, 0, 0, qou_pkg::STAT_FAULT}});
    plan.push_back('{make_req(qou_pkg::REQ_LOAD, 0, 0, 0, 0, 32'h100, 32'h3, MINW, 32'h5),
                     1'b0, '0});
    // Zero dt just normalizes the state.
    plan.push_back('{make_req(qou_pkg::REQ_INTEGRATE, 32'h1, 32'h2, 32'h3, 0, 0, 0, 0, 0),
                     1'b0, '0});
    plan.push_back('{make_req(qou_pkg::REQ_INTEGRATE, 32'h20000, MINW, 32'h1, 16'h8000,
                              0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{make_req(qou_pkg::REQ_INTEGRATE, 0, 0, 0, 16'hffff, 0, 0, 0, 0),
                     1'b0, '0});
    plan.push_back('{make_req(qou_pkg::REQ_LOAD, 0, 0, 0, 0, 32'h1, 0, 0, 0), 1'b0, '0});
    plan.push_back('{make_req(qou_pkg::REQ_ROTATE, 0, 0, MAXW, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{make_req(qou_pkg::REQ_INTEGRATE, 32'hffff_fff0, 32'h7, 32'h10000,
                              16'h0001, 0, 0, 0, 0), 1'b0, '0});

    att_q[0] = ONE; att_q[1] = 0; att_q[2] = 0; att_q[3] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      send_request(plan[r].req);
      // Check the predicted value against the typed-in one; the block is checked on output.
      if (plan[r].has_exp && pending_att[$] !== plan[r].exp) begin
        $display("%0t: mismatch expected %h actual %h", $time, plan[r].exp, pending_att[$]);
        errors++;
      end
    end
    drain();

    // Random phases: none (with the one long receiver hold-off), sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 85 : (ph == 3) ? 23 : 0;
      recv_stall_pct = (ph == 2) ? 85 : (ph == 3) ? 23 : 0;
      if (ph == 0) long_hold = 1'b1;
      for (int n = 0; n < 185; n++) begin
        if (n % 60 == 59) drain();
        send_request(random_request());
      end
    end
    drain();
    repeat (300) @(posedge clk);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: quaternion_orientation_update.f
+incdir+hdl
hdl/qou_pkg.sv
hdl/qou_mul.sv
hdl/qou_sqrt.sv
hdl/qou_div.sv
hdl/quaternion_orientation_update.sv
hdl/qou_checker.sv
dv/quaternion_orientation_update_tb.sv
